// ===== rtl/core/pixelmap_format_blend_front_end_top_assert.svh =====
// Assertion macros used by the checker of the pixel format front end.
`ifndef PIXELMAP_FORMAT_BLEND_FRONT_END_TOP_ASSERT_SVH
`define PIXELMAP_FORMAT_BLEND_FRONT_END_TOP_ASSERT_SVH

// Checked at every rising edge, reset included.
`define PFBFE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

// Checked at every rising edge outside reset.
`define PFBFE_ASSERT_RUN(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

// ===== rtl/core/pfbfe_pkg.sv =====
// Shared types and constants of the pixel format front end.
package pfbfe_pkg;

   localparam int PAL_DEPTH   = 256;
   localparam int PAL_ADDR_W  = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
   localparam int COORD_W     = 16;
   localparam int POS_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int COLOR_W     = 24;
   localparam int ALPHA_W     = 8;

   localparam logic [ALPHA_W-1:0] GLOBAL_ALPHA_RESET = 8'd255;

   typedef enum logic [2:0] {
      MODE_PALETTE,
      MODE_PALETTE_KEY,
      MODE_ARGB4444,
      MODE_RGB565_ALPHA,
      MODE_RGB565,
      MODE_ARGB8888,
      MODE_XRGB,
      MODE_COMPRESSED
   } src_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SOURCE_MODE,
      CSR_GLOBAL_ALPHA,
      CSR_TRANSPARENT_INDEX,
      CSR_CLIP_LEFT,
      CSR_CLIP_TOP,
      CSR_CLIP_RIGHT,
      CSR_CLIP_BOTTOM
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL,
      OP_PALETTE_LOAD
   } opcode_type;

   function automatic logic [POS_W-1:0] coord_to_pos(input logic [COORD_W-1:0] c);
      return POS_W'(signed'(c));
   endfunction

endpackage

// ===== rtl/core/pixelmap_format_blend_front_end_top.sv =====
// Pixel format front end: converts source pixels to RGB plus blend alpha at the cursor position.
//
// One word is accepted per clock while req_stall is low, pixels and palette loads
// alike. A pixel passes the registered palette memory read, the 8 by 8 alpha multiply,
// and the divide by 255 with the drop decision into the output register, before its
// blend request, if kept, appears on rsp_valid. The palette lives in a single memory
// with one write and one registered read port; loads write it as they are accepted, so
// a pixel that follows a load in the next cycle already reads the new entry. A stalled
// output backs the pipeline up, and req_stall rises only when every stage holds a word.
// The palette is not cleared after reset. csr_ready is always high; registers are to be
// written only while the block is idle, which the block itself does not enforce, and a
// clip write returns the cursor to the top left corner.
module pixelmap_format_blend_front_end_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [31:0]                          req_pixel_word,
   input  logic [7:0]                           req_side_alpha,
   input  logic [7:0]                           req_palette_slot,
   input  logic [pfbfe_pkg::COLOR_W-1:0]        req_palette_color,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [pfbfe_pkg::POS_W-1:0]   rsp_pos_x,
   output logic signed [pfbfe_pkg::POS_W-1:0]   rsp_pos_y,
   output logic [pfbfe_pkg::COLOR_W-1:0]        rsp_rgb_color,
   output logic [pfbfe_pkg::ALPHA_W-1:0]        rsp_blend_alpha,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfbfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pfbfe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pfbfe_pkg::*;

   src_mode_type          mode_ff, mode_in;
   logic [ALPHA_W-1:0]    global_ff, global_in;
   logic [7:0]            trans_ff, trans_in;
   logic [COORD_W-1:0]    clip_left_ff, clip_left_in;
   logic [COORD_W-1:0]    clip_top_ff, clip_top_in;
   logic [COORD_W-1:0]    clip_right_ff, clip_right_in;
   logic [COORD_W-1:0]    clip_bottom_ff, clip_bottom_in;
   logic [COORD_W-1:0]    x_ff, x_in;
   logic [COORD_W-1:0]    y_ff, y_in;

   logic [COLOR_W-1:0]    palette_mem [PAL_DEPTH];
   logic [COLOR_W-1:0]    pal_rd_ff;

   logic                  csr_write;
   logic                  clip_write;
   logic                  word_acc;
   logic                  pixel_acc;
   logic                  load_acc;
   logic [7:0]            pix_index;
   logic                  idx_ok;
   logic                  slot_ok;
   logic                  dec_emit;
   logic                  dec_use_pal;
   logic                  dec_scale;
   logic [ALPHA_W-1:0]    dec_asrc;
   logic [COLOR_W-1:0]    dec_color;

   logic                  out_move, s2_move, s1_move;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_emit_ff, s1_emit_in;
   logic                  s1_use_pal_ff, s1_use_pal_in;
   logic                  s1_idx_ok_ff, s1_idx_ok_in;
   logic                  s1_scale_ff, s1_scale_in;
   logic [ALPHA_W-1:0]    s1_asrc_ff, s1_asrc_in;
   logic [COLOR_W-1:0]    s1_color_ff, s1_color_in;
   logic [COORD_W-1:0]    s1_x_ff, s1_x_in;
   logic [COORD_W-1:0]    s1_y_ff, s1_y_in;

   logic [COLOR_W-1:0]    s1_color_sel;
   logic [15:0]           s1_prod;

   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_emit_ff, s2_emit_in;
   logic                  s2_scale_ff, s2_scale_in;
   logic [15:0]           s2_prod_ff, s2_prod_in;
   logic [COLOR_W-1:0]    s2_color_ff, s2_color_in;
   logic [COORD_W-1:0]    s2_x_ff, s2_x_in;
   logic [COORD_W-1:0]    s2_y_ff, s2_y_in;

   logic [16:0]           s2_sum;
   logic [ALPHA_W-1:0]    s2_alpha;
   logic                  s2_keep;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]      rsp_y_ff, rsp_y_in;
   logic [COLOR_W-1:0]    rsp_color_ff, rsp_color_in;
   logic [ALPHA_W-1:0]    rsp_alpha_ff, rsp_alpha_in;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign out_move  = !rsp_valid_ff || !rsp_stall;
   assign s2_move   = !s2_valid_ff || out_move;
   assign s1_move   = !s1_valid_ff || s2_move;
   assign req_stall = !s1_move;

   assign word_acc  = req_valid && !req_stall;
   assign pixel_acc = word_acc && (req_opcode == OP_PIXEL);
   assign load_acc  = word_acc && (req_opcode == OP_PALETTE_LOAD);
   assign pix_index = req_pixel_word[7:0];
   assign idx_ok    = (32'(pix_index) < PAL_DEPTH);
   assign slot_ok   = (32'(req_palette_slot) < PAL_DEPTH);

   always_comb begin
      mode_in        = mode_ff;
      global_in      = global_ff;
      trans_in       = trans_ff;
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_right_in  = clip_right_ff;
      clip_bottom_in = clip_bottom_ff;
      clip_write     = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            CSR_SOURCE_MODE:       mode_in = src_mode_type'(csr_data[2:0]);
            CSR_GLOBAL_ALPHA:      global_in = csr_data[ALPHA_W-1:0];
            CSR_TRANSPARENT_INDEX: trans_in = csr_data[7:0];
            CSR_CLIP_LEFT: begin
               clip_left_in = csr_data[COORD_W-1:0];
               clip_write   = 1'b1;
            end
            CSR_CLIP_TOP: begin
               clip_top_in = csr_data[COORD_W-1:0];
               clip_write  = 1'b1;
            end
            CSR_CLIP_RIGHT: begin
               clip_right_in = csr_data[COORD_W-1:0];
               clip_write    = 1'b1;
            end
            CSR_CLIP_BOTTOM: begin
               clip_bottom_in = csr_data[COORD_W-1:0];
               clip_write     = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      priority if (clip_write) begin
         x_in = clip_left_in;
         y_in = clip_top_in;
      end else if (pixel_acc) begin
         if ($signed(x_ff) >= $signed(clip_right_ff)) begin
            x_in = clip_left_ff;
            if ($signed(y_ff) >= $signed(clip_bottom_ff)) begin
               y_in = clip_top_ff;
            end else begin
               y_in = y_ff + COORD_W'(1);
            end
         end else begin
            x_in = x_ff + COORD_W'(1);
         end
      end else begin
      end
   end

   always_comb begin
      dec_emit    = 1'b0;
      dec_use_pal = 1'b0;
      dec_scale   = 1'b0;
      dec_asrc    = '0;
      dec_color   = '0;
      unique case (mode_ff)
         MODE_PALETTE: begin
            dec_emit    = 1'b1;
            dec_use_pal = 1'b1;
         end
         MODE_PALETTE_KEY: begin
            dec_emit    = (pix_index != trans_ff);
            dec_use_pal = 1'b1;
         end
         MODE_ARGB4444: begin
            dec_emit  = (req_pixel_word[15:12] != 4'd0);
            dec_scale = 1'b1;
            dec_asrc  = {req_pixel_word[15:12], req_pixel_word[15:12]};
            dec_color = {req_pixel_word[11:8], 4'd0, req_pixel_word[7:4], 4'd0,
                         req_pixel_word[3:0], 4'd0};
         end
         MODE_RGB565_ALPHA: begin
            dec_emit  = 1'b1;
            dec_scale = 1'b1;
            dec_asrc  = req_side_alpha;
            dec_color = {req_pixel_word[15:11], 3'd0, req_pixel_word[10:5], 2'd0,
                         req_pixel_word[4:0], 3'd0};
         end
         MODE_RGB565: begin
            dec_emit  = 1'b1;
            dec_color = {req_pixel_word[15:11], 3'd0, req_pixel_word[10:5], 2'd0,
                         req_pixel_word[4:0], 3'd0};
         end
         MODE_ARGB8888: begin
            dec_emit  = 1'b1;
            dec_scale = 1'b1;
            dec_asrc  = req_pixel_word[31:24];
            dec_color = req_pixel_word[23:0];
         end
         MODE_XRGB: begin
            dec_emit  = 1'b1;
            dec_color = req_pixel_word[23:0];
         end
         MODE_COMPRESSED: begin
            dec_emit = 1'b0;
         end
      endcase
   end

   always_comb begin
      s1_valid_in   = s1_move ? pixel_acc : s1_valid_ff;
      s1_emit_in    = s1_emit_ff;
      s1_use_pal_in = s1_use_pal_ff;
      s1_idx_ok_in  = s1_idx_ok_ff;
      s1_scale_in   = s1_scale_ff;
      s1_asrc_in    = s1_asrc_ff;
      s1_color_in   = s1_color_ff;
      s1_x_in       = s1_x_ff;
      s1_y_in       = s1_y_ff;
      if (pixel_acc) begin
         s1_emit_in    = dec_emit;
         s1_use_pal_in = dec_use_pal;
         s1_idx_ok_in  = idx_ok;
         s1_scale_in   = dec_scale;
         s1_asrc_in    = dec_asrc;
         s1_color_in   = dec_color;
         s1_x_in       = x_ff;
         s1_y_in       = y_ff;
      end
   end

   always_comb begin
      if (s1_use_pal_ff) begin
         s1_color_sel = s1_idx_ok_ff ? pal_rd_ff : '0;
      end else begin
         s1_color_sel = s1_color_ff;
      end
      if (s1_scale_ff) begin
         s1_prod = 16'(s1_asrc_ff) * 16'(global_ff);
      end else begin
         s1_prod = 16'(global_ff);
      end
   end

   always_comb begin
      s2_valid_in = s2_move ? s1_valid_ff : s2_valid_ff;
      s2_emit_in  = s2_emit_ff;
      s2_scale_in = s2_scale_ff;
      s2_prod_in  = s2_prod_ff;
      s2_color_in = s2_color_ff;
      s2_x_in     = s2_x_ff;
      s2_y_in     = s2_y_ff;
      if (s2_move && s1_valid_ff) begin
         s2_emit_in  = s1_emit_ff;
         s2_scale_in = s1_scale_ff;
         s2_prod_in  = s1_prod;
         s2_color_in = s1_color_sel;
         s2_x_in     = s1_x_ff;
         s2_y_in     = s1_y_ff;
      end
   end

   // Exact floor division by 255 for any product of two 8-bit values.
   assign s2_sum   = 17'(s2_prod_ff) + 17'(s2_prod_ff[15:8]) + 17'd1;
   assign s2_alpha = s2_scale_ff ? s2_sum[15:8] : s2_prod_ff[ALPHA_W-1:0];
   assign s2_keep  = s2_emit_ff && (s2_alpha != '0);

   always_comb begin
      rsp_valid_in = out_move ? (s2_valid_ff && s2_keep) : rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_alpha_in = rsp_alpha_ff;
      if (out_move && s2_valid_ff && s2_keep) begin
         rsp_x_in     = coord_to_pos(s2_x_ff);
         rsp_y_in     = coord_to_pos(s2_y_ff);
         rsp_color_in = s2_color_ff;
         rsp_alpha_in = s2_alpha;
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc && slot_ok) begin
         palette_mem[req_palette_slot[PAL_ADDR_W-1:0]] <= req_palette_color;
      end
      if (pixel_acc) begin
         pal_rd_ff <= palette_mem[pix_index[PAL_ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_XRGB;
         global_ff      <= GLOBAL_ALPHA_RESET;
         trans_ff       <= '0;
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_right_ff  <= '0;
         clip_bottom_ff <= '0;
         x_ff           <= '0;
         y_ff           <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         global_ff      <= global_in;
         trans_ff       <= trans_in;
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_right_ff  <= clip_right_in;
         clip_bottom_ff <= clip_bottom_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_emit_ff    <= s1_emit_in;
      s1_use_pal_ff <= s1_use_pal_in;
      s1_idx_ok_ff  <= s1_idx_ok_in;
      s1_scale_ff   <= s1_scale_in;
      s1_asrc_ff    <= s1_asrc_in;
      s1_color_ff   <= s1_color_in;
      s1_x_ff       <= s1_x_in;
      s1_y_ff       <= s1_y_in;
      s2_emit_ff    <= s2_emit_in;
      s2_scale_ff   <= s2_scale_in;
      s2_prod_ff    <= s2_prod_in;
      s2_color_ff   <= s2_color_in;
      s2_x_ff       <= s2_x_in;
      s2_y_ff       <= s2_y_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_alpha_ff  <= rsp_alpha_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_rgb_color   = rsp_color_ff;
   assign rsp_blend_alpha = rsp_alpha_ff;

endmodule

// ===== rtl/core/pfbfe_checker.sv =====
// Port-level checker of the pixel format front end and its bind to the top level.
`include "pixelmap_format_blend_front_end_top_assert.svh"

module pfbfe_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 req_opcode,
   input logic [31:0]                          req_pixel_word,
   input logic [7:0]                           req_side_alpha,
   input logic [7:0]                           req_palette_slot,
   input logic [pfbfe_pkg::COLOR_W-1:0]        req_palette_color,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [pfbfe_pkg::POS_W-1:0]   rsp_pos_x,
   input logic signed [pfbfe_pkg::POS_W-1:0]   rsp_pos_y,
   input logic [pfbfe_pkg::COLOR_W-1:0]        rsp_rgb_color,
   input logic [pfbfe_pkg::ALPHA_W-1:0]        rsp_blend_alpha,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [pfbfe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input logic [pfbfe_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pfbfe_pkg::*;

   logic [2*POS_W+COLOR_W+ALPHA_W-1:0] rsp_bus;

   assign rsp_bus = {rsp_pos_x, rsp_pos_y, rsp_rgb_color, rsp_blend_alpha};

   `PFBFE_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "Output word present after reset.")
   `PFBFE_ASSERT_RUN(a_alpha_nonzero, rsp_valid |-> rsp_blend_alpha != '0, "Word with zero alpha.")
   `PFBFE_ASSERT_RUN(a_valid_holds, rsp_valid && rsp_stall |=> rsp_valid, "Stalled word dropped.")
   `PFBFE_ASSERT_RUN(a_word_holds, rsp_valid && rsp_stall |=> $stable(rsp_bus), "Stalled word moved.")

endmodule

bind pixelmap_format_blend_front_end_top pfbfe_checker u_pfbfe_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pixel format front end with a built-in blend predictor.

module tb_top;
   import pfbfe_pkg::*;

   typedef struct packed {
      opcode_type          op;
      logic [31:0]         word;
      logic [7:0]          side;
      logic [7:0]          slot;
      logic [COLOR_W-1:0]  color;
   } pixel_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [COLOR_W-1:0]      color;
      logic [ALPHA_W-1:0]      alpha;
   } blend_req_type;

   typedef struct packed {
      src_mode_type        mode;
      logic [7:0]          galpha;
      logic [7:0]          key;
      pixel_item_type      item;
      logic                typed;
      logic                typed_emit;
      logic [COLOR_W-1:0]  typed_color;
      logic [ALPHA_W-1:0]  typed_alpha;
   } stim_row_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DRAIN_CYCLES = 8;
   localparam int DIR_ROWS     = 26;

   // Clip registers stay at reset in this part, so every typed request sits at (0, 0).
   localparam stim_row_type dir_rows [DIR_ROWS] = '{
      '{MODE_XRGB, 8'd255, 8'h00, '{OP_PIXEL, 32'hFFFF_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'hFF_FFFF, 8'hFF},
      '{MODE_XRGB, 8'd255, 8'h00, '{OP_PIXEL, 32'h0000_0000, 8'hFF, 8'hFF, 24'hFF_FFFF},
        1'b1, 1'b1, 24'h00_0000, 8'hFF},
      '{MODE_XRGB, 8'd255, 8'h00, '{OP_PALETTE_LOAD, 32'hFFFF_FFFF, 8'hFF, 8'h00, 24'h12_3456},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_XRGB, 8'd255, 8'h00, '{OP_PALETTE_LOAD, 32'h0000_0000, 8'h00, 8'hFF, 24'hFF_FFFF},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_XRGB, 8'd255, 8'h00, '{OP_PALETTE_LOAD, 32'h0000_0000, 8'h00, 8'hAA, 24'h00_0000},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_PALETTE, 8'd255, 8'h00, '{OP_PIXEL, 32'hFFFF_FF00, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h12_3456, 8'hFF},
      '{MODE_PALETTE, 8'd255, 8'h00, '{OP_PIXEL, 32'h0000_00FF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'hFF_FFFF, 8'hFF},
      '{MODE_PALETTE, 8'h80, 8'h00, '{OP_PIXEL, 32'h0000_00AA, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h00_0000, 8'h80},
      '{MODE_PALETTE_KEY, 8'd255, 8'h00, '{OP_PIXEL, 32'hFFFF_FF00, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_PALETTE_KEY, 8'd255, 8'h00, '{OP_PIXEL, 32'h0000_00AA, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h00_0000, 8'hFF},
      '{MODE_PALETTE_KEY, 8'd255, 8'hFF, '{OP_PIXEL, 32'h0000_0000, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h12_3456, 8'hFF},
      '{MODE_ARGB4444, 8'd255, 8'hFF, '{OP_PIXEL, 32'hFFFF_0FFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_ARGB4444, 8'd255, 8'hFF, '{OP_PIXEL, 32'h0000_F0F0, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h00_F000, 8'hFF},
      '{MODE_ARGB4444, 8'h80, 8'hFF, '{OP_PIXEL, 32'h1234_8ABC, 8'h00, 8'h00, 24'h0},
        1'b0, 1'b0, 24'h0, 8'h0},
      '{MODE_RGB565_ALPHA, 8'd255, 8'hFF, '{OP_PIXEL, 32'h0000_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_RGB565_ALPHA, 8'd255, 8'hFF, '{OP_PIXEL, 32'h0000_FFFF, 8'hFF, 8'h00, 24'h0},
        1'b1, 1'b1, 24'hF8_FCF8, 8'hFF},
      '{MODE_RGB565_ALPHA, 8'h80, 8'hFF, '{OP_PIXEL, 32'h0000_1234, 8'h80, 8'h00, 24'h0},
        1'b0, 1'b0, 24'h0, 8'h0},
      '{MODE_RGB565, 8'd255, 8'hFF, '{OP_PIXEL, 32'hFFFF_0000, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h00_0000, 8'hFF},
      '{MODE_RGB565, 8'd255, 8'hFF, '{OP_PIXEL, 32'h0000_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'hF8_FCF8, 8'hFF},
      '{MODE_ARGB8888, 8'd255, 8'hFF, '{OP_PIXEL, 32'h00FF_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_ARGB8888, 8'd255, 8'hFF, '{OP_PIXEL, 32'hFFAB_CDEF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'hAB_CDEF, 8'hFF},
      '{MODE_ARGB8888, 8'h80, 8'hFF, '{OP_PIXEL, 32'h8012_3456, 8'h00, 8'h00, 24'h0},
        1'b0, 1'b0, 24'h0, 8'h0},
      '{MODE_ARGB8888, 8'd0, 8'hFF, '{OP_PIXEL, 32'hFFFF_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0},
      '{MODE_ARGB8888, 8'd1, 8'hFF, '{OP_PIXEL, 32'hFE00_0000, 8'h00, 8'h00, 24'h0},
        1'b0, 1'b0, 24'h0, 8'h0},
      '{MODE_XRGB, 8'd1, 8'hFF, '{OP_PIXEL, 32'h0000_0001, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b1, 24'h00_0001, 8'h01},
      '{MODE_COMPRESSED, 8'd255, 8'hFF, '{OP_PIXEL, 32'hFFFF_FFFF, 8'h00, 8'h00, 24'h0},
        1'b1, 1'b0, 24'h0, 8'h0}
   };

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic                     req_opcode;
   logic [31:0]              req_pixel_word;
   logic [7:0]               req_side_alpha;
   logic [7:0]               req_palette_slot;
   logic [COLOR_W-1:0]       req_palette_color;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [POS_W-1:0]  rsp_pos_x;
   logic signed [POS_W-1:0]  rsp_pos_y;
   logic [COLOR_W-1:0]       rsp_rgb_color;
   logic [ALPHA_W-1:0]       rsp_blend_alpha;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   src_mode_type             cfg_mode;
   logic [7:0]               cfg_alpha;
   logic [7:0]               cfg_key;
   logic signed [POS_W-1:0]  clip_l, clip_t, clip_r, clip_b;
   logic signed [POS_W-1:0]  cur_x, cur_y;
   logic [COLOR_W-1:0]       pal_mem [PAL_DEPTH];
   bit                       pal_written [PAL_DEPTH];
   int                       written_slots [$];

   blend_req_type            pending_blends [$];
   int                       mismatches;
   int                       rsp_hold;
   bit                       no_gaps;

   pixelmap_format_blend_front_end_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_pixel_word    (req_pixel_word),
      .req_side_alpha    (req_side_alpha),
      .req_palette_slot  (req_palette_slot),
      .req_palette_color (req_palette_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_rgb_color     (rsp_rgb_color),
      .rsp_blend_alpha   (rsp_blend_alpha),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h, wanted %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   function automatic logic [7:0] scaled(input logic [7:0] a);
      logic [15:0] prod;
      prod = a * cfg_alpha;
      return 8'(prod / 16'd255);
   endfunction

   task automatic predict_blend(input pixel_item_type it, output bit emit,
                                output blend_req_type res);
      logic [31:0] w;
      logic [7:0]  idx;
      emit = 1'b0;
      res = '0;
      w = it.word;
      idx = w[7:0];
      if (it.op == OP_PALETTE_LOAD) begin
         pal_mem[it.slot] = it.color;
         if (!pal_written[it.slot]) begin
            pal_written[it.slot] = 1'b1;
            written_slots.push_back(int'(it.slot));
         end
         return;
      end
      res.x = cur_x;
      res.y = cur_y;
      case (cfg_mode)
         MODE_PALETTE: begin
            res.color = pal_mem[idx];
            res.alpha = cfg_alpha;
            emit = 1'b1;
         end
         MODE_PALETTE_KEY: begin
            if (idx != cfg_key) begin
               res.color = pal_mem[idx];
               res.alpha = cfg_alpha;
               emit = 1'b1;
            end
         end
         MODE_ARGB4444: begin
            if (w[15:12] != 4'h0) begin
               res.alpha = scaled({w[15:12], w[15:12]});
               res.color = {w[11:8], 4'h0, w[7:4], 4'h0, w[3:0], 4'h0};
               emit = 1'b1;
            end
         end
         MODE_RGB565_ALPHA, MODE_RGB565: begin
            res.alpha = (cfg_mode == MODE_RGB565) ? cfg_alpha : scaled(it.side);
            res.color = {w[15:11], 3'b000, w[10:5], 2'b00, w[4:0], 3'b000};
            emit = 1'b1;
         end
         MODE_ARGB8888: begin
            res.alpha = scaled(w[31:24]);
            res.color = w[23:0];
            emit = 1'b1;
         end
         MODE_XRGB: begin
            res.alpha = cfg_alpha;
            res.color = w[23:0];
            emit = 1'b1;
         end
         default: ;
      endcase
      if (cur_x >= clip_r) begin
         cur_x = clip_l;
         if (cur_y >= clip_b) cur_y = clip_t;
         else cur_y = cur_y + 16'sd1;
      end else begin
         cur_x = cur_x + 16'sd1;
      end
      if (res.alpha == 8'd0) emit = 1'b0;
   endtask

   task automatic send_word(input pixel_item_type it, input bit typed, input bit typed_emit,
                            input blend_req_type typed_res);
      int gap;
      bit emit;
      blend_req_type res;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_opcode        = it.op;
      req_pixel_word    = it.word;
      req_side_alpha    = it.side;
      req_palette_slot  = it.slot;
      req_palette_color = it.color;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_blend(it, emit, res);
      if (typed) begin
         emit = typed_emit;
         res = typed_res;
      end
      if (emit) pending_blends.push_back(res);
   endtask

   // A pixel that is dropped may still be in flight once the queue runs empty.
   task automatic settle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_blends.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      case (csr_index_type'(idx))
         CSR_SOURCE_MODE:       cfg_mode = src_mode_type'(data[2:0]);
         CSR_GLOBAL_ALPHA:      cfg_alpha = data[7:0];
         CSR_TRANSPARENT_INDEX: cfg_key = data[7:0];
         CSR_CLIP_LEFT:         clip_l = data;
         CSR_CLIP_TOP:          clip_t = data;
         CSR_CLIP_RIGHT:        clip_r = data;
         CSR_CLIP_BOTTOM:       clip_b = data;
         default: ;
      endcase
      if (idx >= CSR_CLIP_LEFT && idx <= CSR_CLIP_BOTTOM) begin
         cur_x = clip_l;
         cur_y = clip_t;
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall = 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin : take_result
      blend_req_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blends.size() == 0) begin
            report_mismatch("unexpected word", {rsp_pos_x, rsp_pos_y}, 32'h0);
         end else begin
            want = pending_blends.pop_front();
            if (rsp_pos_x !== want.x) report_mismatch("pos_x", 32'(rsp_pos_x), 32'(want.x));
            if (rsp_pos_y !== want.y) report_mismatch("pos_y", 32'(rsp_pos_y), 32'(want.y));
            if (rsp_rgb_color !== want.color)
               report_mismatch("rgb_color", 32'(rsp_rgb_color), 32'(want.color));
            if (rsp_blend_alpha !== want.alpha)
               report_mismatch("blend_alpha", 32'(rsp_blend_alpha), 32'(want.alpha));
         end
         rsp_hold = no_gaps ? 0 : $urandom_range(0, 6);
      end
   end

   initial begin
      stim_row_type            row;
      blend_req_type           typed_res;
      pixel_item_type          it;
      logic [7:0]              idx;
      logic [7:0]              val;
      logic signed [POS_W-1:0] l, r, t, b;
      int                      k, n, phase_len, random_sent;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_PIXEL;
      req_pixel_word    = '0;
      req_side_alpha    = '0;
      req_palette_slot  = '0;
      req_palette_color = '0;
      rsp_stall         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_SOURCE_MODE;
      csr_data          = '0;
      rsp_hold          = 0;
      no_gaps           = 1'b0;
      mismatches        = 0;
      random_sent       = 0;

      cfg_mode  = MODE_XRGB;
      cfg_alpha = GLOBAL_ALPHA_RESET;
      cfg_key   = 8'h00;
      clip_l = '0;
      clip_t = '0;
      clip_r = '0;
      clip_b = '0;
      cur_x  = '0;
      cur_y  = '0;
      for (k = 0; k < PAL_DEPTH; k++) begin
         pal_mem[k] = '0;
         pal_written[k] = 1'b0;
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (k = 0; k < DIR_ROWS; k++) begin
         row = dir_rows[k];
         if (row.mode != cfg_mode || row.galpha != cfg_alpha || row.key != cfg_key) begin
            settle();
            if (row.mode != cfg_mode) write_csr(CSR_SOURCE_MODE, 16'(row.mode));
            if (row.galpha != cfg_alpha) write_csr(CSR_GLOBAL_ALPHA, 16'(row.galpha));
            if (row.key != cfg_key) write_csr(CSR_TRANSPARENT_INDEX, 16'(row.key));
         end
         typed_res = '{16'sd0, 16'sd0, row.typed_color, row.typed_alpha};
         send_word(row.item, row.typed, row.typed_emit, typed_res);
      end

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         no_gaps = ($urandom_range(0, 3) == 0);
         write_csr(CSR_SOURCE_MODE, 16'($urandom));
         case ($urandom_range(0, 5))
            0:       val = 8'd0;
            1:       val = 8'd1;
            2, 3:    val = 8'd255;
            default: val = 8'($urandom);
         endcase
         write_csr(CSR_GLOBAL_ALPHA, {8'($urandom), val});
         if (written_slots.size() != 0 && $urandom_range(0, 1) == 0)
            val = 8'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
         else
            val = 8'($urandom);
         write_csr(CSR_TRANSPARENT_INDEX, {8'($urandom), val});

         if ($urandom_range(0, 2) != 0) begin
            l = 16'($urandom);
            t = 16'($urandom);
            case ($urandom_range(0, 9))
               0: begin
                  l = -16'sd32768;
                  t = -16'sd32768;
                  r = 16'sd32767;
                  b = 16'sd32767;
               end
               1: begin
                  l = 16'sd32764;
                  t = 16'sd32766;
                  r = 16'sd32767;
                  b = 16'sd32767;
               end
               2: begin
                  r = l - 16'($urandom_range(1, 100));
                  b = t - 16'($urandom_range(0, 3));
               end
               3: begin
                  r = l;
                  b = t;
               end
               default: begin
                  r = l + 16'($urandom_range(0, 7));
                  b = t + 16'($urandom_range(0, 4));
                  if (r < l) r = 16'sd32767;
                  if (b < t) b = 16'sd32767;
               end
            endcase
            write_csr(CSR_CLIP_LEFT, l);
            write_csr(CSR_CLIP_TOP, t);
            write_csr(CSR_CLIP_RIGHT, r);
            write_csr(CSR_CLIP_BOTTOM, b);
         end
         if ($urandom_range(0, 4) == 0) write_csr(CSR_UNUSED, 16'($urandom));

         phase_len = $urandom_range(20, 120);
         for (n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
            it.op    = ($urandom_range(0, 6) == 0) ? OP_PALETTE_LOAD : OP_PIXEL;
            it.word  = $urandom;
            it.side  = 8'($urandom);
            it.slot  = 8'($urandom);
            it.color = 24'($urandom);
            // Palette pixels only ever point at entries that have been loaded.
            if (it.op == OP_PIXEL && (cfg_mode == MODE_PALETTE || cfg_mode == MODE_PALETTE_KEY))
            begin
               if (written_slots.size() == 0) begin
                  it.op = OP_PALETTE_LOAD;
               end else begin
                  idx = it.word[7:0];
                  if (cfg_mode == MODE_PALETTE_KEY && $urandom_range(0, 3) == 0) idx = cfg_key;
                  if (!pal_written[idx])
                     idx = 8'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
                  it.word[7:0] = idx;
               end
            end
            send_word(it, 1'b0, 1'b0, '0);
            random_sent++;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_blends.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
